### rtl/core/mecanum_wheel_speed_solver_assert.svh
// Assertion macros for the wheel speed solver checkers.
`ifndef MECANUM_WHEEL_SPEED_SOLVER_ASSERT_SVH
`define MECANUM_WHEEL_SPEED_SOLVER_ASSERT_SVH

// Implication in the same cycle.
`define MWS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication in the next cycle.
`define MWS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/mws_pkg.sv
// Shared types and constants of the mecanum wheel speed solver.
`default_nettype none
package mws_pkg;
	localparam int WHEEL_COUNT = 4;
	localparam logic [17:0] PI_Q16 = 18'd205887;
	localparam int DIV_STEPS = 23;

	localparam logic [2:0] OP_STOP  = 3'd0;
	localparam logic [2:0] OP_FWD   = 3'd1;
	localparam logic [2:0] OP_BACK  = 3'd2;
	localparam logic [2:0] OP_LEFT  = 3'd3;
	localparam logic [2:0] OP_RIGHT = 3'd4;
	localparam logic [2:0] OP_CW    = 3'd5;
	localparam logic [2:0] OP_CCW   = 3'd6;

	localparam logic [1:0] FORM_MECANUM   = 2'd0;
	localparam logic [1:0] FORM_TRANSFORM = 2'd1;

	localparam logic [2:0] REG_MEC_GAIN  = 3'd0;
	localparam logic [2:0] REG_TRF_GAIN  = 3'd1;
	localparam logic [2:0] REG_HALF_SUM  = 3'd2;
	localparam logic [2:0] REG_LIM_FL    = 3'd3;
	localparam logic [2:0] REG_LIM_FR    = 3'd4;
	localparam logic [2:0] REG_LIM_RL    = 3'd5;
	localparam logic [2:0] REG_LIM_RR    = 3'd6;

	typedef struct packed {
		logic [21:0] rem;
		logic [22:0] nlo;
		logic [22:0] quo;
	} div_t;

	typedef struct packed {
		logic                         scale;
		logic [WHEEL_COUNT-1:0]       neg;
		logic [WHEEL_COUNT-1:0][21:0] mag;
		logic [21:0]                  dvsr;
		logic                         servo;
		logic                         stop;
	} side_t;
endpackage
`default_nettype wire

### rtl/core/mecanum_wheel_speed_solver.sv
// Mecanum wheel speed solver: command in, four wheel rpm targets out.
// Usage:
//   s_axis carries one motion command per item: tdata holds speed_mag,
//   tuser holds op and wheel_form. m_axis carries one result per command:
//   tdata holds the four rpm values, tuser the servo_open and hard_stop flags.
//   The cfg channel writes gains, half track sum and wheel limits; cfg_ready
//   is always high. Write it only while no command is in flight.
//   Throughput: one command per cycle unless the m_axis output stalls; the
//   path is a 33 stage pipeline in which 23 stages are a one-bit-per-stage
//   divider for the limit scaling.
//   Reset clears all valid bits and loads the register defaults.
//   When m_axis_tready is low with a result waiting, the whole pipeline holds
//   and s_axis_tready drops in the same cycle; nothing is lost or repeated.
`default_nettype none
module mecanum_wheel_speed_solver (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [15:0] s_axis_tdata,   // [15:0] speed_mag
	input  wire logic [4:0]  s_axis_tuser,   // [2:0] op, [4:3] wheel_form
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [95:0]      m_axis_tdata,   // [23:0] fl, [47:24] fr, [71:48] rl, [95:72] rr
	output logic [1:0]       m_axis_tuser,   // [0] servo_open, [1] hard_stop
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [22:0] cfg_data
);
	localparam int NW = mws_pkg::WHEEL_COUNT;
	localparam int ND = mws_pkg::DIV_STEPS;
	localparam int NPIPE = 9 + ND;

	logic [15:0] mec_gain_q, trf_gain_q, half_sum_q;
	logic [NW-1:0][22:0] lim_q;

	logic adv;
	logic [NPIPE-1:0] valid_q;
	logic out_vld_q;

	// stage registers
	logic signed [16:0] vx_s1, vy_s1, vx_s2, vy_s2, vx_s3, vy_s3, vx_s4, vy_s4;
	logic [16:0] sabs_s1;
	logic rot_en_s1, rot_neg_s1, rot_en_s2, rot_neg_s2, rot_en_s3, rot_neg_s3;
	logic [1:0] form_s1, form_s2, form_s3, form_s4;
	logic stop_s1, stop_s2, stop_s3, stop_s4, stop_s5, stop_s6, stop_s7, stop_s8;
	logic [34:0] prod1_s2;
	logic [50:0] prod2_s3;
	logic signed [19:0] rot_s4;
	logic [NW-1:0][19:0] lmag_s5;
	logic [NW-1:0] neg_s5, neg_s6, neg_s7, neg_s8;
	logic [15:0] gain_s5;
	logic [1:0] form_s5, form_s6, form_s7, form_s8;
	logic [NW-1:0][35:0] prod_s6;
	logic [NW-1:0][21:0] rmag_s7, rmag_s8;
	logic [21:0] max_s8;
	logic [22:0] lim_s8;
	logic scale_s8;

	mws_pkg::div_t  dv_s [0:ND][0:NW-1];
	mws_pkg::side_t sd_s [0:ND];
	logic [95:0] out_data_q;
	logic [1:0]  out_user_q;

	// stage 1 decode
	logic signed [16:0] sext, sneg_v, vx_c, vy_c;
	logic [16:0] sabs_c;
	logic rot_en_c, rot_neg_c, stop_c;

	// stage 4, 5, 7, 8 logic
	logic [50:0] rsum;
	logic [18:0] rmag_c;
	logic signed [19:0] lx, ly, l_c [0:NW-1];
	logic [NW-1:0][19:0] lmag_c;
	logic [NW-1:0] lneg_c;
	logic [NW-1:0][36:0] rnd_c;
	logic [1:0] ia, ib, imax;
	logic [21:0] ma, mb;

	function automatic mws_pkg::div_t div_step(mws_pkg::div_t a, logic [21:0] d);
		mws_pkg::div_t r;
		logic [22:0] t;
		t = {a.rem, a.nlo[22]};
		r.nlo = {a.nlo[21:0], 1'b0};
		if (t >= {1'b0, d}) begin
			t = t - {1'b0, d};
			r.quo = {a.quo[21:0], 1'b1};
		end else begin
			r.quo = {a.quo[21:0], 1'b0};
		end
		r.rem = t[21:0];
		return r;
	endfunction

	assign adv = !out_vld_q || m_axis_tready;
	assign s_axis_tready = adv;
	assign cfg_ready = 1'b1;
	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata = out_data_q;
	assign m_axis_tuser = out_user_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mec_gain_q <= 16'd12223;
			trf_gain_q <= 16'd12223;
			half_sum_q <= 16'd9830;
			lim_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				mws_pkg::REG_MEC_GAIN: mec_gain_q <= cfg_data[15:0];
				mws_pkg::REG_TRF_GAIN: trf_gain_q <= cfg_data[15:0];
				mws_pkg::REG_HALF_SUM: half_sum_q <= cfg_data[15:0];
				mws_pkg::REG_LIM_FL:   lim_q[0] <= cfg_data;
				mws_pkg::REG_LIM_FR:   lim_q[1] <= cfg_data;
				mws_pkg::REG_LIM_RL:   lim_q[2] <= cfg_data;
				mws_pkg::REG_LIM_RR:   lim_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			out_vld_q <= 1'b0;
		end else if (adv) begin
			valid_q <= {valid_q[NPIPE-2:0], s_axis_tvalid};
			out_vld_q <= valid_q[NPIPE-1];
		end
	end

	always_comb begin
		sext = {s_axis_tdata[15], s_axis_tdata};
		sneg_v = 17'sd0 - sext;
		sabs_c = s_axis_tdata[15] ? 17'(17'd0 - {1'b1, s_axis_tdata}) : {1'b0, s_axis_tdata};
		vx_c = '0;
		vy_c = '0;
		rot_en_c = 1'b0;
		rot_neg_c = 1'b0;
		stop_c = 1'b0;
		case (s_axis_tuser[2:0])
			mws_pkg::OP_FWD:   vy_c = sext;
			mws_pkg::OP_BACK:  vy_c = sneg_v;
			mws_pkg::OP_LEFT:  vx_c = sext;
			mws_pkg::OP_RIGHT: vx_c = sneg_v;
			mws_pkg::OP_CW: begin
				rot_en_c = 1'b1;
				rot_neg_c = s_axis_tdata[15];
			end
			mws_pkg::OP_CCW: begin
				rot_en_c = 1'b1;
				rot_neg_c = !s_axis_tdata[15];
			end
			default: stop_c = 1'b1;
		endcase
	end

	always_comb begin
		rsum = prod2_s3 + {19'd0, 1'b1, 31'd0};
		rmag_c = rsum[50:32];
		lx = 20'(vx_s4);
		ly = 20'(vy_s4);
		if (form_s4 == mws_pkg::FORM_MECANUM) begin
			l_c[0] = ly - lx - rot_s4;
			l_c[1] = ly + lx + rot_s4;
			l_c[2] = ly + lx - rot_s4;
			l_c[3] = ly - lx + rot_s4;
		end else if (form_s4 == mws_pkg::FORM_TRANSFORM) begin
			for (int i = 0; i < NW; i++) l_c[i] = ly;
		end else begin
			for (int i = 0; i < NW; i++) l_c[i] = '0;
		end
		for (int i = 0; i < NW; i++) begin
			lneg_c[i] = l_c[i][19];
			lmag_c[i] = l_c[i][19] ? 20'(20'sd0 - l_c[i]) : 20'(l_c[i]);
			rnd_c[i] = {1'b0, prod_s6[i]} + 37'd8192;
		end
		ia = (rmag_s7[1] > rmag_s7[0]) ? 2'd1 : 2'd0;
		ma = (rmag_s7[1] > rmag_s7[0]) ? rmag_s7[1] : rmag_s7[0];
		ib = (rmag_s7[3] > rmag_s7[2]) ? 2'd3 : 2'd2;
		mb = (rmag_s7[3] > rmag_s7[2]) ? rmag_s7[3] : rmag_s7[2];
		imax = (mb > ma) ? ib : ia;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			vx_s1 <= vx_c;
			vy_s1 <= vy_c;
			sabs_s1 <= sabs_c;
			rot_en_s1 <= rot_en_c;
			rot_neg_s1 <= rot_neg_c;
			form_s1 <= s_axis_tuser[4:3];
			stop_s1 <= stop_c;

			prod1_s2 <= 35'(sabs_s1 * mws_pkg::PI_Q16);
			{vx_s2, vy_s2, rot_en_s2, rot_neg_s2, form_s2, stop_s2} <=
				{vx_s1, vy_s1, rot_en_s1, rot_neg_s1, form_s1, stop_s1};

			prod2_s3 <= 51'(prod1_s2 * half_sum_q);
			{vx_s3, vy_s3, rot_en_s3, rot_neg_s3, form_s3, stop_s3} <=
				{vx_s2, vy_s2, rot_en_s2, rot_neg_s2, form_s2, stop_s2};

			if (!rot_en_s3) rot_s4 <= '0;
			else if (rot_neg_s3) rot_s4 <= 20'sd0 - $signed({1'b0, rmag_c});
			else rot_s4 <= $signed({1'b0, rmag_c});
			{vx_s4, vy_s4, form_s4, stop_s4} <= {vx_s3, vy_s3, form_s3, stop_s3};

			lmag_s5 <= lmag_c;
			neg_s5 <= lneg_c;
			gain_s5 <= (form_s4 == mws_pkg::FORM_TRANSFORM) ? trf_gain_q : mec_gain_q;
			form_s5 <= form_s4;
			stop_s5 <= stop_s4;

			for (int i = 0; i < NW; i++) prod_s6[i] <= 36'(lmag_s5[i] * gain_s5);
			{neg_s6, form_s6, stop_s6} <= {neg_s5, form_s5, stop_s5};

			for (int i = 0; i < NW; i++) rmag_s7[i] <= rnd_c[i][35:14];
			{neg_s7, form_s7, stop_s7} <= {neg_s6, form_s6, stop_s6};

			rmag_s8 <= rmag_s7;
			max_s8 <= (mb > ma) ? mb : ma;
			lim_s8 <= lim_q[imax];
			scale_s8 <= (lim_q[imax] != 23'd0) &&
				({1'b0, ((mb > ma) ? mb : ma)} > lim_q[imax]);
			{neg_s8, form_s8, stop_s8} <= {neg_s7, form_s7, stop_s7};

			for (int i = 0; i < NW; i++) begin
				dv_s[0][i].rem <= 22'(((46'(rmag_s8[i]) * lim_s8) + 46'(max_s8 >> 1)) >> 23);
				dv_s[0][i].nlo <= 23'((46'(rmag_s8[i]) * lim_s8) + 46'(max_s8 >> 1));
				dv_s[0][i].quo <= '0;
			end
			sd_s[0].scale <= scale_s8;
			sd_s[0].neg <= neg_s8;
			sd_s[0].mag <= rmag_s8;
			sd_s[0].dvsr <= max_s8;
			sd_s[0].servo <= (form_s8 == mws_pkg::FORM_TRANSFORM);
			sd_s[0].stop <= stop_s8;

			for (int k = 0; k < ND; k++) begin
				for (int i = 0; i < NW; i++) dv_s[k+1][i] <= div_step(dv_s[k][i], sd_s[k].dvsr);
				sd_s[k+1] <= sd_s[k];
			end

			for (int i = 0; i < NW; i++) begin
				if (sd_s[ND].scale)
					out_data_q[i*24 +: 24] <= sd_s[ND].neg[i] ?
						24'(24'd0 - {1'b0, dv_s[ND][i].quo}) : {1'b0, dv_s[ND][i].quo};
				else
					out_data_q[i*24 +: 24] <= sd_s[ND].neg[i] ?
						24'(24'd0 - {2'b0, sd_s[ND].mag[i]}) : {2'b0, sd_s[ND].mag[i]};
			end
			out_user_q <= {sd_s[ND].stop, sd_s[ND].servo};
		end
	end
endmodule
`default_nettype wire

### rtl/core/mws_chk.sv
// Port checker for the mecanum wheel speed solver, bound to the top level.
`default_nettype none
`include "mecanum_wheel_speed_solver_assert.svh"
module mws_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tready,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [95:0] m_axis_tdata,
	input wire logic [1:0]  m_axis_tuser
);
	logic out_stall, wheels_eq;

	assign out_stall = m_axis_tvalid && !m_axis_tready;
	assign wheels_eq = (m_axis_tdata[23:0] == m_axis_tdata[47:24]) &&
		(m_axis_tdata[47:24] == m_axis_tdata[71:48]) &&
		(m_axis_tdata[71:48] == m_axis_tdata[95:72]);

	`MWS_ASSERT_NEXT(a_hold_valid, out_stall, m_axis_tvalid, "item dropped")
	`MWS_ASSERT_NEXT(a_hold_data, out_stall, $stable(m_axis_tdata), "item changed")
	`MWS_ASSERT_NOW(a_stop_zero, m_axis_tvalid && m_axis_tuser[1], m_axis_tdata == 96'd0, "stop")
	`MWS_ASSERT_NOW(a_servo_eq, m_axis_tvalid && m_axis_tuser[0], wheels_eq, "wheels differ")
	`MWS_ASSERT_NOW(a_ready_empty, !m_axis_tvalid, s_axis_tready, "not ready while empty")
endmodule

bind mecanum_wheel_speed_solver mws_chk u_mws_chk (.*);
`default_nettype wire
